[hw/rtl/pre_pkg.sv]
package pre_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'd1;

  // Datapath operations issued by the microcode
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_KINIT,
    OP_DIV,
    OP_KINC,
    OP_CINC,
    OP_PRIME,
    OP_EXHAUST
  } op_t;

  // Control from sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic exec;
    logic in_ready;
  } ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic req;
    logic div_busy;
    logic out_free;
    logic ge_high;
    logic k_over;
    logic rem_zero;
  } status_t;

endpackage

[hw/rtl/prime_range_enumerator.sv]
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------
// in       in_valid / in_ready  restart
// out      out_valid/out_ready  prime_value, found
// cfg      cfg_write            cfg_index, cfg_data
//
// Each request scans candidates by trial division; each divisor test is
// run by the bit-serial remainder unit.
// Synchronous reset: range_low = range_high = next_candidate = 2, idle.
// A finished result sits in the output register while the next request is
// taken; only a new result waits for that register to be freed.
module prime_range_enumerator #(
  parameter int unsigned NUM_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [NUM_WIDTH-1:0]          prime_value,
  output logic                          found,
  input  logic                          cfg_write,
  input  logic [pre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [NUM_WIDTH-1:0]          cfg_data
);

  localparam logic [NUM_WIDTH-1:0] TWO = NUM_WIDTH'(2);

  logic [NUM_WIDTH-1:0] range_low;
  logic [NUM_WIDTH-1:0] range_high;
  logic [NUM_WIDTH-1:0] next_candidate;
  logic [NUM_WIDTH-1:0] cand;
  logic [NUM_WIDTH-1:0] k;
  logic [NUM_WIDTH-1:0] start_val;
  logic                 div_start;
  logic                 div_busy;
  logic                 rem_zero;
  logic                 run;

  pre_pkg::ctrl_t   ctrl;
  pre_pkg::status_t status;

  pre_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  pre_rem_unit #(.W(NUM_WIDTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cand),
    .divisor  (k),
    .busy     (div_busy),
    .rem_zero (rem_zero)
  );

  assign in_ready  = ctrl.in_ready;
  assign run       = ctrl.exec;
  assign div_start = run && (ctrl.op == pre_pkg::OP_DIV);

  // Scan start point, never below two
  always_comb begin
    start_val = restart ? range_low : next_candidate;
    if (start_val < TWO) begin
      start_val = TWO;
    end
  end

  assign status.req      = in_valid;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || out_ready;
  assign status.ge_high  = (cand >= range_high);
  assign status.k_over   = (k > (cand >> 1));
  assign status.rem_zero = rem_zero;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= TWO;
      range_high <= TWO;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pre_pkg::CFG_RANGE_LOW:  range_low  <= cfg_data;
        pre_pkg::CFG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Candidate and divisor datapath
  always_ff @(posedge clk) begin
    if (run) begin
      unique case (ctrl.op)
        pre_pkg::OP_LOAD:  cand <= start_val;
        pre_pkg::OP_KINIT: k    <= TWO;
        pre_pkg::OP_KINC:  k    <= k + 1'b1;
        pre_pkg::OP_CINC:  cand <= cand + 1'b1;
        default: ;
      endcase
    end
  end

  // Scan position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      next_candidate <= TWO;
      out_valid      <= 1'b0;
    end else begin
      if (run && ctrl.op == pre_pkg::OP_PRIME) begin
        next_candidate <= cand + 1'b1;
        prime_value    <= cand;
        found          <= 1'b1;
        out_valid      <= 1'b1;
      end else if (run && ctrl.op == pre_pkg::OP_EXHAUST) begin
        next_candidate <= cand;
        prime_value    <= '0;
        found          <= 1'b0;
        out_valid      <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/pre_rem_unit.sv]
// Restoring remainder unit, one quotient bit per cycle
module pre_rem_unit #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         rem_zero
);

  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  dvd;
  logic [W-1:0]  dsr;
  logic [W:0]    rem;
  logic [W:0]    rem_shift;
  logic [W:0]    rem_sub;
  logic [CW-1:0] cnt;

  // Shift in next dividend bit, trial subtract
  assign rem_shift = {rem[W-1:0], dvd[W-1]};
  assign rem_sub   = rem_shift - {1'b0, dsr};
  assign rem_zero  = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      cnt  <= CW'(W - 1);
    end else if (busy) begin
      dvd <= {dvd[W-2:0], 1'b0};
      rem <= (rem_shift >= {1'b0, dsr}) ? rem_sub : rem_shift;
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/pre_sequencer.sv]
// Microcode sequencer: step counter, control store, conditional jumps
module pre_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  pre_pkg::status_t status,
  output pre_pkg::ctrl_t   ctrl
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'd0,
    S_RANGE   = 4'd1,
    S_KINIT   = 4'd2,
    S_KCHK    = 4'd3,
    S_DIV     = 4'd4,
    S_DWAIT   = 4'd5,
    S_KINC    = 4'd6,
    S_CINC    = 4'd7,
    S_PRIME   = 4'd8,
    S_EXHAUST = 4'd9
  } step_t;

  typedef enum logic [1:0] {
    H_NONE,
    H_REQ,
    H_DIV,
    H_OUT
  } hold_t;

  typedef enum logic [2:0] {
    J_SEQ,
    J_ALWAYS,
    J_GE_HIGH,
    J_K_OVER,
    J_REM_ZERO
  } jump_t;

  typedef struct packed {
    pre_pkg::op_t op;
    hold_t        hold;
    jump_t        jump;
    step_t        target;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{op: pre_pkg::OP_NOP, hold: H_NONE, jump: J_ALWAYS, target: S_IDLE};
    unique case (s)
      S_IDLE:    w = '{op: pre_pkg::OP_LOAD,    hold: H_REQ,  jump: J_SEQ,      target: S_IDLE};
      S_RANGE:   w = '{op: pre_pkg::OP_NOP,     hold: H_NONE, jump: J_GE_HIGH,  target: S_EXHAUST};
      S_KINIT:   w = '{op: pre_pkg::OP_KINIT,   hold: H_NONE, jump: J_SEQ,      target: S_IDLE};
      S_KCHK:    w = '{op: pre_pkg::OP_NOP,     hold: H_NONE, jump: J_K_OVER,   target: S_PRIME};
      S_DIV:     w = '{op: pre_pkg::OP_DIV,     hold: H_NONE, jump: J_SEQ,      target: S_IDLE};
      S_DWAIT:   w = '{op: pre_pkg::OP_NOP,     hold: H_DIV,  jump: J_REM_ZERO, target: S_CINC};
      S_KINC:    w = '{op: pre_pkg::OP_KINC,    hold: H_NONE, jump: J_ALWAYS,   target: S_KCHK};
      S_CINC:    w = '{op: pre_pkg::OP_CINC,    hold: H_NONE, jump: J_ALWAYS,   target: S_RANGE};
      S_PRIME:   w = '{op: pre_pkg::OP_PRIME,   hold: H_OUT,  jump: J_ALWAYS,   target: S_IDLE};
      S_EXHAUST: w = '{op: pre_pkg::OP_EXHAUST, hold: H_OUT,  jump: J_ALWAYS,   target: S_IDLE};
      default:   w = '{op: pre_pkg::OP_NOP,     hold: H_NONE, jump: J_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   go;
  logic   take;

  assign uw = ucode(pc);

  // Hold stalls the step and suppresses its operation
  always_comb begin
    unique case (uw.hold)
      H_NONE:  go = 1'b1;
      H_REQ:   go = status.req;
      H_DIV:   go = !status.div_busy;
      H_OUT:   go = status.out_free;
      default: go = 1'b1;
    endcase
  end

  // Branch condition
  always_comb begin
    unique case (uw.jump)
      J_SEQ:      take = 1'b0;
      J_ALWAYS:   take = 1'b1;
      J_GE_HIGH:  take = status.ge_high;
      J_K_OVER:   take = status.k_over;
      J_REM_ZERO: take = status.rem_zero;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      pc_next = take ? uw.target : step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.op       = uw.op;
  assign ctrl.exec     = go;
  assign ctrl.in_ready = (pc == S_IDLE);

endmodule
